// ===== sv/i4ep_pkg.sv =====
// ----------------------------------------------------------------------------
// i4ep_pkg: shared types and helpers for the 4x4 intra edge predictor
// Holds the mode codes, the stage payload structs and the rounding helpers.
// ----------------------------------------------------------------------------
package i4ep_pkg;

   localparam int MODE_W     = 4;
   localparam int PIX_W      = 8;
   localparam int EDGE_N     = 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_VP8_VERT              = 4'd0,
      MODE_VP8_HOR               = 4'd1,
      MODE_SVQ3_DOWNLEFT         = 4'd2,
      MODE_RV40_DOWNLEFT         = 4'd3,
      MODE_RV40_DOWNLEFT_NODOWN  = 4'd4,
      MODE_RV40_VERTLEFT         = 4'd5,
      MODE_RV40_VERTLEFT_NODOWN  = 4'd6,
      MODE_VP8_VERTLEFT          = 4'd7,
      MODE_RV40_HORUP            = 4'd8,
      MODE_RV40_HORUP_NODOWN     = 4'd9,
      MODE_VP8_TRUEMOTION        = 4'd10
   } mode_type;

   // Edge pixels after the down-left substitution.
   typedef struct packed {
      logic [MODE_W-1:0]             mode;
      logic [PIX_W-1:0]              corner;
      logic [EDGE_N-1:0][PIX_W-1:0]  top;
      logic [EDGE_N-1:0][PIX_W-1:0]  left;
   } edge_type;

   // Partial filter sums shared among the modes.
   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [6:0][8:0]     pt;    // top[i] + top[i+1]
      logic [6:0][8:0]     pl;    // left[i] + left[i+1]
      logic [5:0][9:0]     st;    // top[i] + 2*top[i+1] + top[i+2]
      logic [5:0][9:0]     sl;    // left[i] + 2*left[i+1] + left[i+2]
      logic [9:0]          ct;    // corner + 2*top[0] + top[1]
      logic [9:0]          cl;    // corner + 2*left[0] + left[1]
      logic [9:0]          et;    // top[6] + 3*top[7]
      logic [9:0]          el;    // left[2] + 3*left[3]
      logic [2:0][8:0]     lt;    // left[k] + top[k] for k = 1..3
      logic [3:0][3:0][9:0] tm;   // left[y] + top[x] - corner, two's complement
   } tap_type;

   function automatic logic [10:0] sum11(input logic [9:0] a, input logic [9:0] b);
      sum11 = {1'b0, a} + {1'b0, b};
   endfunction

   function automatic logic [7:0] avg2(input logic [8:0] x);
      logic [9:0] s;
      s = {1'b0, x} + 10'd1;
      avg2 = s[8:1];
   endfunction

   function automatic logic [7:0] avg4(input logic [9:0] x);
      logic [10:0] s;
      s = {1'b0, x} + 11'd2;
      avg4 = s[9:2];
   endfunction

   function automatic logic [7:0] avg8(input logic [10:0] x);
      logic [11:0] s;
      s = {1'b0, x} + 12'd4;
      avg8 = s[10:3];
   endfunction

   // Saturate a signed 10-bit value to 0..255.
   function automatic logic [7:0] clip8(input logic [9:0] x);
      if (x[9]) begin
         clip8 = 8'd0;
      end else if (x[8]) begin
         clip8 = 8'd255;
      end else begin
         clip8 = x[7:0];
      end
   endfunction

endpackage

// ===== sv/intra4x4_edge_predictor.sv =====
// ----------------------------------------------------------------------------
// intra4x4_edge_predictor: 4x4 intra prediction from edge pixels
// Predicts the sixteen pixels of a 4x4 block from its neighbors and a mode.
// ----------------------------------------------------------------------------
// Usage: the req channel carries one block's neighbor pixels per transfer,
// with the prediction mode on req_tuser. The rsp channel returns one transfer
// per request holding all sixteen predicted pixels, in request order.
// The block is a three-stage pipeline: an input register that applies the
// down-left substitution, a tap stage that forms the shared filter sums, and
// an output stage that rounds, selects by mode and holds the result.
// A request passes the edge, tap and output stage registers in that order,
// and rsp_tvalid rises once it sits in the output register. A new request
// is taken in every cycle while rsp_tready is high, so the sustained rate is
// then one block per cycle; the stage registers set that figure.
// Each stage holds its item while the stage after it is full and held, and
// req_tready falls only when all three stages are full and rsp_tready is low.
// A stalled result stays on rsp_tdata unchanged until its transfer completes.
// Reset clears the stage valid bits; the block then holds no item. Unused
// mode codes predict all pixels as zero.
// ----------------------------------------------------------------------------
module intra4x4_edge_predictor (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // corner [7:0], top_row [71:8], left_col [135:72]
   input  logic [135:0]  req_tdata,
   // mode [3:0]
   input  logic [3:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // rows_upper [63:0], rows_lower [127:64]
   output logic [127:0]  rsp_tdata
);
   import i4ep_pkg::*;

   edge_type edge_q;
   tap_type  tap_q;
   logic     edge_valid, edge_ready;
   logic     tap_valid, tap_ready;

   // Stage one: unpack the request and substitute the down-left pixels.
   i4ep_edge_stage u_edge (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_mode     (req_tuser),
      .in_corner   (req_tdata[7:0]),
      .in_top_row  (req_tdata[71:8]),
      .in_left_col (req_tdata[135:72]),
      .out_valid   (edge_valid),
      .out_ready   (edge_ready),
      .out_edge    (edge_q)
   );

   // Stage two: two-tap and three-tap sums and TrueMotion differences.
   i4ep_tap_stage u_tap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (edge_valid),
      .in_ready  (edge_ready),
      .in_edge   (edge_q),
      .out_valid (tap_valid),
      .out_ready (tap_ready),
      .out_tap   (tap_q)
   );

   // Stage three: final rounding, mode select and the output register.
   i4ep_pixel_stage u_pixel (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (tap_valid),
      .in_ready   (tap_ready),
      .in_tap     (tap_q),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_pixels (rsp_tdata)
   );

endmodule

// ===== sv/i4ep_edge_stage.sv =====
// ----------------------------------------------------------------------------
// i4ep_edge_stage: input register stage
// Unpacks the edge pixels and replaces the down-left pixels where asked.
// ----------------------------------------------------------------------------
module i4ep_edge_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [3:0]                 in_mode,
   input  logic [7:0]                 in_corner,
   input  logic [63:0]                in_top_row,
   input  logic [63:0]                in_left_col,
   output logic                       out_valid,
   input  logic                       out_ready,
   output i4ep_pkg::edge_type         out_edge
);
   import i4ep_pkg::*;

   logic     valid_ff, valid_in;
   edge_type edge_ff, edge_in;
   logic     nodown;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign nodown   = (in_mode == MODE_RV40_DOWNLEFT_NODOWN)
                  || (in_mode == MODE_RV40_VERTLEFT_NODOWN)
                  || (in_mode == MODE_RV40_HORUP_NODOWN);

   always_comb begin
      edge_in.mode   = in_mode;
      edge_in.corner = in_corner;
      edge_in.top    = in_top_row;
      edge_in.left   = in_left_col;
      if (nodown) begin
         for (int i = 4; i < EDGE_N; i++) begin
            edge_in.left[i] = in_left_col[31:24];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         edge_ff <= edge_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_edge  = edge_ff;

endmodule

// ===== sv/i4ep_tap_stage.sv =====
// ----------------------------------------------------------------------------
// i4ep_tap_stage: filter tap stage
// Forms the two- and three-tap sums and the TrueMotion differences.
// ----------------------------------------------------------------------------
module i4ep_tap_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  i4ep_pkg::edge_type         in_edge,
   output logic                       out_valid,
   input  logic                       out_ready,
   output i4ep_pkg::tap_type          out_tap
);
   import i4ep_pkg::*;

   logic    valid_ff, valid_in;
   tap_type tap_ff, tap_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      tap_in.mode = in_edge.mode;
      for (int i = 0; i < 7; i++) begin
         tap_in.pt[i] = {1'b0, in_edge.top[i]} + {1'b0, in_edge.top[i+1]};
         tap_in.pl[i] = {1'b0, in_edge.left[i]} + {1'b0, in_edge.left[i+1]};
      end
      for (int i = 0; i < 6; i++) begin
         tap_in.st[i] = {1'b0, tap_in.pt[i]} + {1'b0, tap_in.pt[i+1]};
         tap_in.sl[i] = {1'b0, tap_in.pl[i]} + {1'b0, tap_in.pl[i+1]};
      end
      tap_in.ct = {2'b0, in_edge.corner} + {2'b0, in_edge.top[0]} + {1'b0, tap_in.pt[0]};
      tap_in.cl = {2'b0, in_edge.corner} + {2'b0, in_edge.left[0]} + {1'b0, tap_in.pl[0]};
      tap_in.et = {1'b0, tap_in.pt[6]} + {1'b0, in_edge.top[7], 1'b0};
      tap_in.el = {1'b0, tap_in.pl[2]} + {1'b0, in_edge.left[3], 1'b0};
      for (int k = 0; k < 3; k++) begin
         tap_in.lt[k] = {1'b0, in_edge.left[k+1]} + {1'b0, in_edge.top[k+1]};
      end
      for (int y = 0; y < 4; y++) begin
         for (int x = 0; x < 4; x++) begin
            tap_in.tm[y][x] = {2'b0, in_edge.left[y]} + {2'b0, in_edge.top[x]}
                            - {2'b0, in_edge.corner};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         tap_ff <= tap_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tap   = tap_ff;

endmodule

// ===== sv/i4ep_pixel_stage.sv =====
// ----------------------------------------------------------------------------
// i4ep_pixel_stage: pixel output stage
// Finishes each mode's rounding and selects the sixteen pixels by mode.
// ----------------------------------------------------------------------------
module i4ep_pixel_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  i4ep_pkg::tap_type          in_tap,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [127:0]               out_pixels
);
   import i4ep_pkg::*;

   logic              valid_ff, valid_in;
   logic [15:0][7:0]  pix_ff, pix_in;
   logic [15:0][7:0]  p_vert, p_hor, p_svq3, p_dl, p_vl, p_vp8vl, p_hu, p_tm;
   tap_type           t;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign t        = in_tap;

   always_comb begin
      logic [7:0] a0, a1, a2, a3;
      logic [7:0] h0, h1, h2, h3;
      // Smoothed vertical and horizontal.
      a0 = avg4(t.ct);
      a1 = avg4(t.st[0]);
      a2 = avg4(t.st[1]);
      a3 = avg4(t.st[2]);
      h0 = avg4(t.cl);
      h1 = avg4(t.sl[0]);
      h2 = avg4(t.sl[1]);
      h3 = avg4(t.el);
      p_vert = {4{a3, a2, a1, a0}};
      p_hor  = {{4{h3}}, {4{h2}}, {4{h1}}, {4{h0}}};

      for (int y = 0; y < 4; y++) begin
         for (int x = 0; x < 4; x++) begin
            // Down-left variants run along the anti-diagonal x + y.
            if (x + y == 0) begin
               p_svq3[4*y+x] = t.lt[0][8:1];
            end else if (x + y == 1) begin
               p_svq3[4*y+x] = t.lt[1][8:1];
            end else begin
               p_svq3[4*y+x] = t.lt[2][8:1];
            end
            if (x + y < 6) begin
               p_dl[4*y+x] = avg8(sum11(t.st[x+y], t.sl[x+y]));
            end else begin
               p_dl[4*y+x] = avg4({1'b0, t.pt[6]} + {1'b0, t.pl[6]});
            end
            p_tm[4*y+x] = clip8(t.tm[y][x]);
         end
      end

      // RV40 vertical-left.
      p_vl[0]  = avg8(sum11({t.pt[0], 1'b0}, t.sl[1]));
      p_vl[1]  = avg2(t.pt[1]);
      p_vl[2]  = avg2(t.pt[2]);
      p_vl[3]  = avg2(t.pt[3]);
      p_vl[4]  = avg8(sum11(t.st[0], t.sl[2]));
      p_vl[5]  = avg4(t.st[1]);
      p_vl[6]  = avg4(t.st[2]);
      p_vl[7]  = avg4(t.st[3]);
      p_vl[8]  = avg2(t.pt[1]);
      p_vl[9]  = avg2(t.pt[2]);
      p_vl[10] = avg2(t.pt[3]);
      p_vl[11] = avg2(t.pt[4]);
      p_vl[12] = avg4(t.st[1]);
      p_vl[13] = avg4(t.st[2]);
      p_vl[14] = avg4(t.st[3]);
      p_vl[15] = avg4(t.st[4]);

      // VP8 vertical-left differs in pixels 0, 4, 11 and 15 only.
      p_vp8vl     = p_vl;
      p_vp8vl[0]  = avg2(t.pt[0]);
      p_vp8vl[4]  = avg4(t.st[0]);
      p_vp8vl[11] = avg4(t.st[4]);
      p_vp8vl[15] = avg4(t.st[5]);

      // RV40 horizontal-up.
      p_hu[0]  = avg8(sum11(t.st[1], {t.pl[0], 1'b0}));
      p_hu[1]  = avg8(sum11(t.st[2], t.sl[0]));
      p_hu[2]  = avg8(sum11(t.st[3], {t.pl[1], 1'b0}));
      p_hu[4]  = p_hu[2];
      p_hu[3]  = avg8(sum11(t.st[4], t.sl[1]));
      p_hu[5]  = p_hu[3];
      p_hu[6]  = avg8(sum11(t.st[5], {t.pl[2], 1'b0}));
      p_hu[8]  = p_hu[6];
      p_hu[7]  = avg8(sum11(t.et, t.el));
      p_hu[9]  = p_hu[7];
      p_hu[11] = avg4(t.sl[3]);
      p_hu[13] = p_hu[11];
      p_hu[12] = avg4({1'b0, t.pt[6]} + {1'b0, t.pl[3]});
      p_hu[10] = p_hu[12];
      p_hu[14] = avg2(t.pl[4]);
      p_hu[15] = avg4(t.sl[4]);
   end

   always_comb begin
      unique case (t.mode)
         MODE_VP8_VERT:             pix_in = p_vert;
         MODE_VP8_HOR:              pix_in = p_hor;
         MODE_SVQ3_DOWNLEFT:        pix_in = p_svq3;
         MODE_RV40_DOWNLEFT,
         MODE_RV40_DOWNLEFT_NODOWN: pix_in = p_dl;
         MODE_RV40_VERTLEFT,
         MODE_RV40_VERTLEFT_NODOWN: pix_in = p_vl;
         MODE_VP8_VERTLEFT:         pix_in = p_vp8vl;
         MODE_RV40_HORUP,
         MODE_RV40_HORUP_NODOWN:    pix_in = p_hu;
         MODE_VP8_TRUEMOTION:       pix_in = p_tm;
         default:                   pix_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         pix_ff <= pix_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_pixels = pix_ff;

endmodule
